@@ hdl/htfd_pkg.sv @@
package htfd_pkg;

  localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;

  localparam logic [7:0] CRC_INIT = 8'hFF;
  localparam logic [7:0] CRC_POLY = 8'h31;

  localparam logic [1:0] STATUS_OK  = 2'd0;
  localparam logic [1:0] STATUS_CRC = 2'd1;
  localparam logic [1:0] STATUS_BUS = 2'd2;

  localparam logic [2:0] IDX_T_HI   = 3'd0;
  localparam logic [2:0] IDX_T_LO   = 3'd1;
  localparam logic [2:0] IDX_T_CRC  = 3'd2;
  localparam logic [2:0] IDX_H_HI   = 3'd3;
  localparam logic [2:0] IDX_H_LO   = 3'd4;
  localparam logic [2:0] IDX_H_CRC  = 3'd5;

  localparam logic [14:0] SCALE_TEMP    = 15'd17500;
  localparam logic [13:0] SCALE_HUMID_A = 14'd10000;
  localparam logic [13:0] SCALE_HUMID_B = 14'd12500;
  localparam logic [16:0] RAW_FULL      = 17'd65535;

  // Classified frame handed from the front end to the arithmetic back end.
  typedef struct packed {
    logic        fail;
    logic        crc_ok;
    logic [15:0] raw_t;
    logic [15:0] raw_h;
  } htfd_item_t;

  function automatic logic [7:0] crc8_step(input logic [7:0] crc_in, input logic [7:0] data);
    logic [7:0] c;
    c = crc_in ^ data;
    for (int b = 0; b < 8; b++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

@@ hdl/htfd_front.sv @@
module htfd_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          rx_byte,
  input  logic                bus_fail,
  input  logic                q_full,
  output logic                push,
  output htfd_pkg::htfd_item_t push_item
);
  import htfd_pkg::*;

  logic [2:0]  byte_index;
  logic [7:0]  crc;
  logic        t_ok;
  logic [15:0] raw_t;
  logic [15:0] raw_h;
  logic        accept;
  logic        last_byte;

  assign in_stall  = q_full;
  assign accept    = in_valid && !in_stall;
  assign last_byte = (byte_index >= IDX_H_CRC);
  assign push      = accept && (bus_fail || last_byte);

  always_comb begin
    push_item.fail   = bus_fail;
    push_item.crc_ok = t_ok && (crc == rx_byte);
    push_item.raw_t  = raw_t;
    push_item.raw_h  = raw_h;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index <= IDX_T_HI;
    end else if (accept) begin
      if (bus_fail || last_byte) begin
        byte_index <= IDX_T_HI;
      end else begin
        byte_index <= byte_index + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !bus_fail) begin
      unique case (byte_index)
        IDX_T_HI: begin
          raw_t[15:8] <= rx_byte;
          crc <= crc8_step(CRC_INIT, rx_byte);
        end
        IDX_T_LO: begin
          raw_t[7:0] <= rx_byte;
          crc <= crc8_step(crc, rx_byte);
        end
        IDX_T_CRC: begin
          t_ok <= (crc == rx_byte);
        end
        IDX_H_HI: begin
          raw_h[15:8] <= rx_byte;
          crc <= crc8_step(CRC_INIT, rx_byte);
        end
        IDX_H_LO: begin
          raw_h[7:0] <= rx_byte;
          crc <= crc8_step(crc, rx_byte);
        end
        default: begin
        end
      endcase
    end
  end

  a_index_range: assert property (@(posedge clk) disable iff (rst) byte_index <= IDX_H_CRC)
    else $error("byte index out of range");
  a_push_on_accept: assert property (@(posedge clk) disable iff (rst) push |-> accept)
    else $error("push without an accepted byte");
  a_index_advance: assert property (@(posedge clk) disable iff (rst)
      (accept && !bus_fail && !last_byte) |=> (byte_index == $past(byte_index) + 3'd1))
    else $error("byte index did not advance");

endmodule

@@ hdl/htfd_queue.sv @@
module htfd_queue #(
  parameter int unsigned DEPTH = htfd_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  htfd_pkg::htfd_item_t push_item,
  output logic                 full,
  output logic                 q_valid,
  output htfd_pkg::htfd_item_t q_item,
  input  logic                 pop
);
  import htfd_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  htfd_item_t       mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full    = (count == CNT_W'(DEPTH));
  assign q_valid = (count != '0);
  assign q_item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst) count <= CNT_W'(DEPTH))
    else $error("queue count overflow");
  a_no_push_full: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) pop |-> q_valid)
    else $error("pop from empty queue");

endmodule

@@ hdl/htfd_back.sv @@
module htfd_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 family,
  input  logic                 q_valid,
  input  htfd_pkg::htfd_item_t q_item,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [14:0]   temp_centi,
  output logic [13:0]          humid_centi,
  output logic [1:0]           status
);
  import htfd_pkg::*;

  // Floor of x / 65535 for x no larger than 17500 * 65535.
  function automatic logic [14:0] div_full(input logic [30:0] x);
    logic [14:0] q0;
    logic [16:0] r;
    q0 = x[30:16];
    r  = {1'b0, x[15:0]} + {2'b00, q0};
    return (r >= RAW_FULL) ? q0 + 15'd1 : q0;
  endfunction

  logic        s1_valid;
  logic [30:0] s1_prod_t;
  logic [29:0] s1_prod_h;
  logic [1:0]  s1_status;
  logic        s1_family;
  logic        s1_load;
  logic        out_load;

  logic [14:0]        q_t;
  logic [14:0]        q_h;
  logic signed [15:0] t_full;
  logic signed [15:0] h_off;
  logic [13:0]        h_val;
  logic [1:0]         st_next;

  assign out_load = !out_valid || !out_stall;
  assign s1_load  = !s1_valid || out_load;
  assign pop      = q_valid && s1_load;

  always_comb begin
    if (q_item.fail) begin
      st_next = STATUS_BUS;
    end else if (!q_item.crc_ok) begin
      st_next = STATUS_CRC;
    end else begin
      st_next = STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_load) begin
      s1_valid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_prod_t <= 31'(SCALE_TEMP) * 31'(q_item.raw_t);
      s1_prod_h <= 30'(family ? SCALE_HUMID_B : SCALE_HUMID_A) * 30'(q_item.raw_h);
      s1_status <= st_next;
      s1_family <= family;
    end
  end

  always_comb begin
    q_t    = div_full(s1_prod_t);
    q_h    = div_full({1'b0, s1_prod_h});
    t_full = $signed({1'b0, q_t}) - 16'sd4500;
    h_off  = $signed({1'b0, q_h}) - 16'sd600;
    if (!s1_family) begin
      h_val = q_h[13:0];
    end else if (h_off < 16'sd0) begin
      h_val = 14'd0;
    end else if (h_off > 16'sd10000) begin
      h_val = 14'd10000;
    end else begin
      h_val = h_off[13:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && s1_valid) begin
      status <= s1_status;
      if (s1_status == STATUS_OK) begin
        temp_centi  <= t_full[14:0];
        humid_centi <= h_val;
      end else begin
        temp_centi  <= '0;
        humid_centi <= '0;
      end
    end
  end

  a_status_code: assert property (@(posedge clk) disable iff (rst)
      out_valid |-> (status == STATUS_OK || status == STATUS_CRC || status == STATUS_BUS))
    else $error("undefined status code");
  a_zero_on_error: assert property (@(posedge clk) disable iff (rst)
      (out_valid && status != STATUS_OK) |-> (temp_centi == '0 && humid_centi == '0))
    else $error("nonzero values with error status");
  a_humid_range: assert property (@(posedge clk) disable iff (rst)
      out_valid |-> (humid_centi <= 14'd10000))
    else $error("humidity out of range");

endmodule

@@ hdl/humidity_temp_frame_decode.sv @@
// Channel   Direction  Handshake                Payload
// in        input      in_valid / in_stall      rx_byte, bus_fail
// out       output     out_valid / out_stall    temp_centi, humid_centi, status
// cfg       input      cfg_valid / cfg_ready    sensor_family
//
// One byte is taken per cycle while in_stall is low; a result passes through the queue entry,
// the multiply stage and the output register after the sixth byte or a bus failure transfers.
// The multiply stage feeds the divide-by-65535 correction ahead of the output register;
// the back end sustains one result per cycle while out_stall is low.
// Reset is synchronous and clears the byte count, the queue and the valid flags.
// Input stalls only when the queue between front and back end is full.
module humidity_temp_frame_decode #(
  parameter int unsigned QUEUE_DEPTH = htfd_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         rx_byte,
  input  logic               bus_fail,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [14:0] temp_centi,
  output logic [13:0]        humid_centi,
  output logic [1:0]         status,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               sensor_family
);
  import htfd_pkg::*;

  logic       family;
  logic       q_full;
  logic       push;
  logic       q_valid;
  logic       pop;
  htfd_item_t push_item;
  htfd_item_t q_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      family <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      family <= sensor_family;
    end
  end

  htfd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .rx_byte   (rx_byte),
    .bus_fail  (bus_fail),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  htfd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .pop       (pop)
  );

  htfd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .family      (family),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .temp_centi  (temp_centi),
    .humid_centi (humid_centi),
    .status      (status)
  );

endmodule
